FILE: sv/mrnp_pkg.sv
// Shared types, codes and constants of the multi-radix number parser.
package mrnp_pkg;

  localparam int MAX_TEXT_DEF = 255;

  localparam logic [31:0] OVF_VALUE = 32'h00ff_ffff;
  localparam logic [31:0] DEC_LIMIT = 32'd429496729;
  localparam logic [31:0] HEX_MASK  = 32'hf000_0000;
  localparam logic [31:0] OCT_MASK  = 32'he000_0000;
  localparam logic [31:0] BIN_MASK  = 32'h8000_0000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_SKIP,
    PH_ZERO,
    PH_HEX,
    PH_OCT,
    PH_BIN,
    PH_DEC
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_OVF   = 2'd2
  } status_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic [7:0]  consumed;
    status_t     status;
  } mrnp_res_t;

endpackage

FILE: sv/mrnp_step.sv
// Combinational per-character parse step: next state and optional result.
module mrnp_step
  import mrnp_pkg::*;
#(
  parameter int MAX_TEXT = MAX_TEXT_DEF,
  localparam int PW = $clog2(MAX_TEXT + 1)
) (
  input  logic [7:0]    ch,
  input  logic          first,
  input  phase_t        phase,
  input  logic [31:0]   acc,
  input  logic [PW-1:0] pos,
  input  logic          seen,
  output phase_t        phase_nxt,
  output logic [31:0]   acc_nxt,
  output logic [PW-1:0] pos_nxt,
  output logic          seen_nxt,
  output mrnp_res_t     res
);

  phase_t          eff_phase;
  phase_t          rp;
  logic [31:0]     eff_acc;
  logic [PW-1:0]   eff_pos;
  logic            eff_seen;
  logic [PW-1:0]   pos_bump;
  logic [PW+7:0]   pos_ext;
  logic [7:0]      pos_sat;
  logic [31:0]     dacc;
  logic            dseen;
  logic [3:0]      dval;
  logic            dok;
  logic            ovf;
  logic [31:0]     acc_new;

  assign eff_phase = first ? PH_SKIP : phase;
  assign eff_acc   = first ? '0 : acc;
  assign eff_pos   = first ? '0 : pos;
  assign eff_seen  = first ? 1'b0 : seen;

  assign pos_bump = (eff_pos < PW'(MAX_TEXT)) ? eff_pos + PW'(1) : eff_pos;
  assign pos_ext  = {8'd0, eff_pos};
  assign pos_sat  = (pos_ext > (PW+8)'(255)) ? 8'hff : pos_ext[7:0];

  // Radix and starting accumulator used if this character is a digit.
  always_comb begin
    rp    = eff_phase;
    dacc  = eff_acc;
    dseen = eff_seen;
    if (eff_phase == PH_SKIP) begin
      rp    = PH_DEC;
      dacc  = '0;
      dseen = 1'b0;
    end else if (eff_phase == PH_ZERO) begin
      rp    = PH_OCT;
      dacc  = '0;
      dseen = 1'b0;
    end
  end

  always_comb begin
    dval = 4'd0;
    dok  = 1'b0;
    case (rp)
      PH_BIN: begin
        dok  = (ch == CH_0) || (ch == CH_1);
        dval = 4'(ch - CH_0);
      end
      PH_OCT: begin
        dok  = (ch >= CH_0) && (ch <= CH_7);
        dval = 4'(ch - CH_0);
      end
      PH_DEC: begin
        dok  = (ch >= CH_0) && (ch <= CH_9);
        dval = 4'(ch - CH_0);
      end
      default: begin
        if ((ch >= CH_0) && (ch <= CH_9)) begin
          dok  = 1'b1;
          dval = 4'(ch - CH_0);
        end else if ((ch >= CH_UA) && (ch <= CH_UF)) begin
          dok  = 1'b1;
          dval = 4'(ch - CH_UA + 8'd10);
        end else if ((ch >= CH_LA) && (ch <= CH_LF)) begin
          dok  = 1'b1;
          dval = 4'(ch - CH_LA + 8'd10);
        end
      end
    endcase
  end

  always_comb begin
    case (rp)
      PH_HEX: begin
        ovf     = (dacc & HEX_MASK) != '0;
        acc_new = {dacc[27:0], 4'd0} + {28'd0, dval};
      end
      PH_OCT: begin
        ovf     = (dacc & OCT_MASK) != '0;
        acc_new = {dacc[28:0], 3'd0} + {28'd0, dval};
      end
      PH_BIN: begin
        ovf     = (dacc & BIN_MASK) != '0;
        acc_new = {dacc[30:0], dval[0]};
      end
      default: begin
        ovf     = (dacc > DEC_LIMIT) || ((dacc == DEC_LIMIT) && ({4'd0, dval} > (CH_5 - CH_0)));
        acc_new = {dacc[28:0], 3'd0} + {dacc[30:0], 1'b0} + {28'd0, dval};
      end
    endcase
  end

  always_comb begin
    phase_nxt    = eff_phase;
    acc_nxt      = eff_acc;
    pos_nxt      = eff_pos;
    seen_nxt     = eff_seen;
    res.emit     = 1'b0;
    res.value    = '0;
    res.consumed = '0;
    res.status   = ST_FOUND;
    if ((eff_phase == PH_SKIP) && (ch >= 8'd1) && (ch <= CH_SPACE)) begin
      pos_nxt = pos_bump;
    end else if ((eff_phase == PH_SKIP) && (ch == CH_0)) begin
      pos_nxt   = pos_bump;
      phase_nxt = PH_ZERO;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
    end else if ((eff_phase == PH_SKIP) && ((ch == CH_LB) || (ch == CH_UB))) begin
      pos_nxt   = pos_bump;
      phase_nxt = PH_BIN;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
    end else if ((eff_phase == PH_ZERO) && ((ch == CH_LX) || (ch == CH_UX))) begin
      pos_nxt   = pos_bump;
      phase_nxt = PH_HEX;
    end else if ((eff_phase == PH_ZERO) && !dok) begin
      // lone zero
      res.emit     = 1'b1;
      res.consumed = pos_sat;
      phase_nxt    = PH_DONE;
    end else if (eff_phase != PH_DONE) begin
      acc_nxt  = dacc;
      seen_nxt = dseen;
      if (!dok) begin
        res.emit     = 1'b1;
        res.value    = dseen ? dacc : '0;
        res.consumed = dseen ? pos_sat : '0;
        res.status   = dseen ? ST_FOUND : ST_NONE;
        phase_nxt    = PH_DONE;
      end else if (ovf) begin
        res.emit   = 1'b1;
        res.value  = OVF_VALUE;
        res.status = ST_OVF;
        phase_nxt  = PH_DONE;
      end else begin
        acc_nxt   = acc_new;
        seen_nxt  = 1'b1;
        pos_nxt   = pos_bump;
        phase_nxt = rp;
      end
    end
  end

endmodule

FILE: sv/multi_radix_number_parser.sv
// Top level of the multi-radix number parser: input register, parse state, result register.
//
// Parses one unsigned 32-bit number from a character stream, one character per
// input transfer. Assert in_first with the first character of each text; leading
// codes 1..32 are skipped, then "0x"/"0X" selects hex, '0' plus an octal digit
// selects octal, a lone '0' is zero, 'b'/'B' selects binary, otherwise decimal.
// The first non-digit (NUL included) produces one result: status 0 with the value
// and the character count, status 1 (value 0, count 0) when no digit was found,
// or status 2 (value 0xffffff, count 0) at the digit that overflows. Later characters give nothing
// until the next in_first. Rate: one character per clock, sustained; the character
// that ends the number is held in the input register and its result is loaded into
// the result register once that register is free, which raises out_valid. The only
// stall comes from out_ready held low with a result waiting. No clearing pass is
// needed after reset.
module multi_radix_number_parser
  import mrnp_pkg::*;
#(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [7:0]  out_consumed,
  output logic [1:0]  out_status
);

  localparam int PW = $clog2(MAX_TEXT + 1);

  // input register
  logic          s1_valid_r;
  logic [7:0]    s1_ch_r;
  logic          s1_first_r;
  logic          s1_adv;

  // parse state
  phase_t        phase_r, phase_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          seen_r, seen_nxt;

  // result register
  logic          out_valid_r;
  logic [31:0]   value_r;
  logic [7:0]    consumed_r;
  status_t       status_r;

  mrnp_res_t     res;

  // The held character is processed once the result register can take its result.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r    <= in_ch;
      s1_first_r <= in_first;
    end
  end

  mrnp_step #(
    .MAX_TEXT (MAX_TEXT)
  ) u_step (
    .ch        (s1_ch_r),
    .first     (s1_first_r),
    .phase     (phase_r),
    .acc       (acc_r),
    .pos       (pos_r),
    .seen      (seen_r),
    .phase_nxt (phase_nxt),
    .acc_nxt   (acc_nxt),
    .pos_nxt   (pos_nxt),
    .seen_nxt  (seen_nxt),
    .res       (res)
  );

  // Parse state advances with every processed character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      acc_r   <= '0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.emit) begin
      value_r    <= res.value;
      consumed_r <= res.consumed;
      status_r   <= res.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_consumed = consumed_r;
  assign out_status   = status_r;

`ifndef SYNTHESIS
  a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OVF)) |-> ((out_value == OVF_VALUE) && (out_consumed == '0)))
    else $error("overflow result with wrong value or count");

  a_none_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NONE)) |-> ((out_value == '0) && (out_consumed == '0)))
    else $error("no-number result with nonzero value or count");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FOUND)) |-> (out_consumed != '0))
    else $error("number found with zero count");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");
`endif

endmodule
